// ===== rtl/cdfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cdfd_pkg
// Shared types, constants and segment tables for the charlieplexed digit
// frame display.
// ----------------------------------------------------------------------------
package cdfd_pkg;

    localparam int FRAME_BYTES_DEF = 8;
    localparam int HDR_BYTES       = 4;

    localparam logic [7:0]  ASCII_ZERO     = 8'd48;
    localparam logic [7:0]  ASCII_NINE     = 8'd57;
    localparam logic [7:0]  BLANK_VALUE    = 8'd11;
    localparam logic [7:0]  MAX_DIGIT      = 8'd9;
    localparam logic [7:0]  RESET_VALUE    = 8'd10;
    localparam logic [3:0]  BLANK_PATTERN  = 4'd11;
    localparam logic [3:0]  INVALID_PATTERN = 4'd10;
    localparam logic [15:0] DEFAULT_PERIOD = 16'd1000;

    localparam logic [0:0] REG_DIGIT_POSITION = 1'd0;
    localparam logic [0:0] REG_DISPLAY_PERIOD = 1'd1;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BYTE_CHK,
        ST_HDR_RD,
        ST_HDR_CMP,
        ST_TIME_RD,
        ST_TIME_POP,
        ST_TICK_CHK,
        ST_DIV,
        ST_DIV_END,
        ST_LIGHT,
        ST_FINISH
    } cdfd_state_t;

    typedef struct packed {
        logic       start;
        logic       push;
        logic       pop;
        logic [1:0] idx;
        logic       capture;
        logic       set_acc;
        logic       latch;
        logic       div_start;
        logic       div_step;
        logic       div_load;
        logic       light;
        logic       load_out;
    } cdfd_cmd_t;

    typedef struct packed {
        logic full;
        logic hdr_match;
        logic ticks_zero;
        logic held_blank;
        logic div_last;
    } cdfd_status_t;

    function automatic logic [7:0] hdr_byte(input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = 8'd6;
            2'd1:    b = 8'd5;
            2'd2:    b = 8'd4;
            2'd3:    b = 8'd3;
            default: b = 8'd6;
        endcase
        return b;
    endfunction

    function automatic logic [2:0] pattern_len(input logic [3:0] p);
        logic [2:0] n;
        case (p)
            4'd0:    n = 3'd6;
            4'd1:    n = 3'd2;
            4'd2:    n = 3'd5;
            4'd3:    n = 3'd5;
            4'd4:    n = 3'd4;
            4'd5:    n = 3'd5;
            4'd6:    n = 3'd6;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd7;
            4'd9:    n = 3'd5;
            4'd10:   n = 3'd3;
            default: n = 3'd3;
        endcase
        return n;
    endfunction

    // segment list per pattern, 3 bits per entry, entry 0 in the low bits
    function automatic logic [2:0] pattern_seg(input logic [3:0] p, input logic [2:0] i);
        logic [20:0] row;
        case (p)
            4'd0:    row = {3'd0, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
            4'd1:    row = {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd1};
            4'd2:    row = {3'd0, 3'd0, 3'd6, 3'd4, 3'd3, 3'd1, 3'd0};
            4'd3:    row = {3'd0, 3'd0, 3'd6, 3'd3, 3'd2, 3'd1, 3'd0};
            4'd4:    row = {3'd0, 3'd0, 3'd0, 3'd6, 3'd5, 3'd2, 3'd1};
            4'd5:    row = {3'd0, 3'd0, 3'd6, 3'd5, 3'd3, 3'd2, 3'd0};
            4'd6:    row = {3'd0, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd0};
            4'd7:    row = {3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd1, 3'd0};
            4'd8:    row = {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
            4'd9:    row = {3'd0, 3'd0, 3'd6, 3'd5, 3'd2, 3'd1, 3'd0};
            4'd10:   row = {3'd0, 3'd0, 3'd0, 3'd0, 3'd6, 3'd3, 3'd0};
            default: row = '0;
        endcase
        return row[3*i +: 3];
    endfunction

    // anode / cathode pin per segment A..G
    function automatic logic [2:0] seg_anode(input logic [2:0] s);
        logic [2:0] a;
        case (s)
            3'd0, 3'd1, 3'd2: a = 3'd2;
            3'd3, 3'd4, 3'd5: a = 3'd0;
            3'd6:             a = 3'd3;
            default:          a = 3'd2;
        endcase
        return a;
    endfunction

    function automatic logic [2:0] seg_cathode(input logic [2:0] s);
        logic [2:0] c;
        case (s)
            3'd0:    c = 3'd4;
            3'd1:    c = 3'd3;
            3'd2:    c = 3'd0;
            3'd3:    c = 3'd4;
            3'd4:    c = 3'd3;
            3'd5:    c = 3'd2;
            3'd6:    c = 3'd4;
            default: c = 3'd4;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/cdfd_datapath.sv =====
// ----------------------------------------------------------------------------
// cdfd_datapath
// Frame fifo, held value, segment scan, remainder unit and result registers.
// ----------------------------------------------------------------------------
module cdfd_datapath
    import cdfd_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  cdfd_cmd_t    cmd,
    output cdfd_status_t st,
    input  logic [7:0]   s_byte_value,
    input  logic         cfg_wr_en,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    output logic [4:0]   m_drive_enable,
    output logic [4:0]   m_drive_high,
    output logic         m_frame_accepted,
    output logic [7:0]   m_shown_value
);

    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam int CNT_W = $clog2(FRAME_BYTES + 1);

    logic [7:0]       fifo_mem [FRAME_BYTES];
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] head_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       byte_in;

    logic [1:0]  digit_pos_reg;
    logic [15:0] period_reg;

    logic [7:0]  held_reg;
    logic [3:0]  latched_reg;
    logic [2:0]  seg_reg;
    logic [2:0]  seg_inc;
    logic [15:0] ticks_reg;

    logic [2:0]  rem_reg;
    logic [3:0]  div_cnt_reg;
    logic [2:0]  len;
    logic [3:0]  shifted;
    logic [2:0]  rem_next;

    logic [4:0]  res_en_reg;
    logic [4:0]  res_hi_reg;
    logic        res_acc_reg;
    logic [2:0]  seg_code;
    logic [2:0]  anode;
    logic [2:0]  cathode;

    // ascii digits become their numeric value
    assign byte_in = (s_byte_value >= ASCII_ZERO && s_byte_value <= ASCII_NINE) ?
                     s_byte_value - ASCII_ZERO : s_byte_value;
    assign wr_idx  = head_reg + count_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            fifo_mem[wr_idx] <= byte_in;
        end
        rd_data_reg <= fifo_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.push) begin
            count_reg <= count_reg + 1'b1;
        end else if (cmd.pop) begin
            head_reg <= head_reg + 1'b1;
            if (count_reg != '0) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_pos_reg <= '0;
            period_reg    <= DEFAULT_PERIOD;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DIGIT_POSITION: digit_pos_reg <= cfg_wdata[1:0];
                REG_DISPLAY_PERIOD: period_reg    <= cfg_wdata;
                default:            period_reg    <= period_reg;
            endcase
        end
    end

    // remainder of period by pattern length, one bit per step
    assign len      = pattern_len(latched_reg);
    assign shifted  = {rem_reg, period_reg[div_cnt_reg]};
    assign rem_next = (shifted >= {1'b0, len}) ? 3'(shifted - {1'b0, len}) : shifted[2:0];

    assign seg_code = pattern_seg(latched_reg, seg_reg);
    assign anode    = seg_anode(seg_code);
    assign cathode  = seg_cathode(seg_code);
    assign seg_inc  = seg_reg + 3'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= RESET_VALUE;
            latched_reg <= INVALID_PATTERN;
            seg_reg     <= '0;
            ticks_reg   <= '0;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            res_en_reg  <= '0;
            res_hi_reg  <= '0;
            res_acc_reg <= 1'b0;
        end else begin
            if (cmd.start) begin
                res_en_reg  <= '0;
                res_hi_reg  <= '0;
                res_acc_reg <= 1'b0;
            end
            if (cmd.capture && cmd.idx == digit_pos_reg) begin
                held_reg <= rd_data_reg;
            end
            if (cmd.set_acc) begin
                res_acc_reg <= 1'b1;
            end
            if (cmd.latch) begin
                seg_reg <= '0;
                if (held_reg == BLANK_VALUE) begin
                    latched_reg <= BLANK_PATTERN;
                end else if (held_reg <= MAX_DIGIT) begin
                    latched_reg <= held_reg[3:0];
                end else begin
                    latched_reg <= INVALID_PATTERN;
                end
            end
            if (cmd.div_start) begin
                rem_reg     <= '0;
                div_cnt_reg <= 4'd15;
            end
            if (cmd.div_step) begin
                rem_reg     <= rem_next;
                div_cnt_reg <= div_cnt_reg - 4'd1;
            end
            if (cmd.div_load) begin
                ticks_reg <= period_reg - {13'd0, rem_reg};
            end
            if (cmd.light && ticks_reg != '0 && latched_reg <= INVALID_PATTERN) begin
                res_en_reg <= 5'(5'd1 << anode) | 5'(5'd1 << cathode);
                res_hi_reg <= 5'(5'd1 << anode);
                seg_reg    <= (seg_inc >= len) ? 3'd0 : seg_inc;
                ticks_reg  <= ticks_reg - 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_drive_enable   <= res_en_reg;
            m_drive_high     <= res_hi_reg;
            m_frame_accepted <= res_acc_reg;
            m_shown_value    <= held_reg;
        end
    end

    assign st.full       = (count_reg == CNT_W'(FRAME_BYTES));
    assign st.hdr_match  = (rd_data_reg == hdr_byte(cmd.idx));
    assign st.ticks_zero = (ticks_reg == '0);
    assign st.held_blank = (held_reg == BLANK_VALUE);
    assign st.div_last   = (div_cnt_reg == 4'd0);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FRAME_BYTES))
        else $error("fifo count beyond depth");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> !st.full)
        else $error("push into full fifo");

    a_light_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !st.ticks_zero |-> latched_reg <= INVALID_PATTERN && seg_reg < len)
        else $error("scan running with bad pattern or index");

endmodule

// ===== rtl/cdfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdfd_ctrl
// Sequencer for byte framing and tick handling, plus the result valid flag.
// ----------------------------------------------------------------------------
module cdfd_ctrl
    import cdfd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_operation,
    output logic         m_valid,
    input  logic         m_ready,
    output cdfd_cmd_t    cmd,
    input  cdfd_status_t st
);

    cdfd_state_t state_reg, state_next;
    logic [1:0]  idx_reg, idx_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        m_valid_next = (m_valid_reg && !m_ready);
        cmd          = '0;
        cmd.idx      = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start = 1'b1;
                    idx_next  = '0;
                    if (s_operation == OP_BYTE) begin
                        cmd.push   = 1'b1;
                        state_next = ST_BYTE_CHK;
                    end else begin
                        state_next = ST_TICK_CHK;
                    end
                end
            end
            ST_BYTE_CHK: begin
                state_next = st.full ? ST_HDR_RD : ST_FINISH;
            end
            // read data is registered, so it follows the head pointer in the next cycle
            ST_HDR_RD: begin
                state_next = ST_HDR_CMP;
            end
            ST_HDR_CMP: begin
                cmd.pop = 1'b1;
                if (!st.hdr_match) begin
                    state_next = ST_FINISH;
                end else if (idx_reg == 2'd3) begin
                    idx_next   = '0;
                    state_next = ST_TIME_RD;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_HDR_RD;
                end
            end
            ST_TIME_RD: begin
                state_next = ST_TIME_POP;
            end
            ST_TIME_POP: begin
                cmd.pop     = 1'b1;
                cmd.capture = 1'b1;
                if (idx_reg == 2'd3) begin
                    cmd.set_acc = 1'b1;
                    state_next  = ST_FINISH;
                end else begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_TIME_RD;
                end
            end
            ST_TICK_CHK: begin
                if (st.ticks_zero) begin
                    cmd.latch = 1'b1;
                    if (st.held_blank) begin
                        state_next = ST_FINISH;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end else begin
                    state_next = ST_LIGHT;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_last) begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END: begin
                cmd.div_load = 1'b1;
                state_next   = ST_LIGHT;
            end
            ST_LIGHT: begin
                cmd.light  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> out_free)
        else $error("result overwritten before taken");

    a_accept_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg != ST_IDLE)
        else $error("accepted request left no work");

    a_pop_only_framing: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> (state_reg == ST_HDR_CMP || state_reg == ST_TIME_POP))
        else $error("pop outside framing");

endmodule

// ===== rtl/charlieplex_digit_frame_display.sv =====
// ----------------------------------------------------------------------------
// charlieplex_digit_frame_display
// Framed serial time bytes drive one charlieplexed seven-segment digit.
// ----------------------------------------------------------------------------
// a byte that does not fill the fifo goes straight to its result; one that fills it
//   has its header bytes checked in turn up to the first mismatch, then the four time bytes popped
// a tick relatches the value once the ticks have run out; for a value that is not blank
//   the remainder unit walks the 16 period bits one per cycle, then a segment is lit
// one request in work at a time: the next is taken only once its result has loaded
// reset clears control, empties the fifo, shown value and pattern go to ten
module charlieplex_digit_frame_display
    import cdfd_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_byte_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_drive_enable,
    output logic [4:0]  m_drive_high,
    output logic        m_frame_accepted,
    output logic [7:0]  m_shown_value,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    cdfd_cmd_t    cmd;
    cdfd_status_t st;

    cdfd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .st          (st)
    );

    cdfd_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .st               (st),
        .s_byte_value     (s_byte_value),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .m_drive_enable   (m_drive_enable),
        .m_drive_high     (m_drive_high),
        .m_frame_accepted (m_frame_accepted),
        .m_shown_value    (m_shown_value)
    );

    a_frame_no_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_accepted) |-> m_drive_enable == 5'd0)
        else $error("frame result drives pins");

    a_high_only_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_drive_high & ~m_drive_enable) == 5'd0)
        else $error("level set on undriven pin");

    a_two_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_drive_enable == 5'd0 || $countones(m_drive_enable) == 2))
        else $error("segment drive not one anode and one cathode");

endmodule

// ===== sim/charlieplex_digit_frame_display_tb.sv =====
// ----------------------------------------------------------------------------
// charlieplex_digit_frame_display_tb
// Self-checking bench for the framed-time charlieplexed digit. Bytes and
// millisecond ticks are sent over the request channel. A local model of the
// frame fifo, the header match, the held value and the segment walk predicts
// every result, and each result is checked field by field as it leaves.
// ----------------------------------------------------------------------------
module charlieplex_digit_frame_display_tb;
    import cdfd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLDOFF       = 300;
    localparam int REPORT_CAP    = 50;

    // header bytes in arrival order, first byte in the low bits
    localparam logic [31:0] FRAME_HEADER = {8'd3, 8'd4, 8'd5, 8'd6};
    // pins per segment, segment A in the low bits
    localparam logic [20:0] ANODE_PINS   = {3'd3, 3'd0, 3'd0, 3'd0, 3'd2, 3'd2, 3'd2};
    localparam logic [20:0] CATHODE_PINS = {3'd4, 3'd2, 3'd3, 3'd4, 3'd0, 3'd3, 3'd4};

    typedef struct packed {
        logic [4:0] drive_enable;
        logic [4:0] drive_high;
        logic       frame_accepted;
        logic [7:0] shown_value;
    } digit_drive_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic [7:0]  s_byte_value;
    logic        m_valid;
    logic        m_ready;
    logic [4:0]  m_drive_enable;
    logic [4:0]  m_drive_high;
    logic        m_frame_accepted;
    logic [7:0]  m_shown_value;
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_wdata;

    // local copy of the digit state
    logic [7:0]  frame_store [8];
    logic [2:0]  fifo_rd          = '0;
    logic [3:0]  fifo_fill        = '0;
    logic [7:0]  held_digit       = RESET_VALUE;
    logic [3:0]  lit_pattern      = INVALID_PATTERN;
    logic [2:0]  seg_step         = '0;
    logic [15:0] ticks_to_relatch = '0;
    logic [1:0]  shown_slot       = '0;
    logic [15:0] display_period   = DEFAULT_PERIOD;

    digit_drive_t awaited_drives [$];

    int  mismatches     = 0;
    int  results_seen   = 0;
    int  requests_sent  = 0;
    int  cycle_count    = 0;
    int  ready_holdoff  = 0;
    bit  sender_idles   = 1'b1;
    bit  receiver_idles = 1'b1;

    charlieplex_digit_frame_display u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_byte_value     (s_byte_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive_enable   (m_drive_enable),
        .m_drive_high     (m_drive_high),
        .m_frame_accepted (m_frame_accepted),
        .m_shown_value    (m_shown_value),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** charlieplex_digit_frame_display: FAILED **");
            $finish;
        end
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // lit segments per pattern, bit n is segment n (A..G)
    function automatic logic [6:0] seg_mask(input logic [3:0] pattern);
        logic [6:0] m;
        case (pattern)
            4'd0:    m = 7'b0111111;
            4'd1:    m = 7'b0000110;
            4'd2:    m = 7'b1011011;
            4'd3:    m = 7'b1001111;
            4'd4:    m = 7'b1100110;
            4'd5:    m = 7'b1101101;
            4'd6:    m = 7'b1111101;
            4'd7:    m = 7'b0000111;
            4'd8:    m = 7'b1111111;
            4'd9:    m = 7'b1100111;
            default: m = 7'b1001001;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] pop_frame_byte();
        logic [7:0] v;
        v = frame_store[fifo_rd];
        fifo_rd = fifo_rd + 3'd1;
        if (fifo_fill > 0) fifo_fill = fifo_fill - 4'd1;
        return v;
    endfunction

    function automatic logic [7:0] random_time_byte();
        logic [7:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = 8'($urandom_range(0, 9));
            4, 5, 6:    v = ASCII_ZERO + 8'($urandom_range(0, 9));
            7:          v = BLANK_VALUE;
            default:    v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    // advance the local digit state by one accepted request
    task automatic step_digit(input logic op, input logic [7:0] raw);
        digit_drive_t r;
        logic [7:0]   c;
        logic [2:0]   slot;
        logic [6:0]   segs;
        logic [15:0]  len;
        logic [2:0]   seg;
        logic [2:0]   anode;
        logic [2:0]   cathode;
        int           found;
        r = '0;
        seg = '0;
        if (op == OP_BYTE) begin
            c = (raw >= ASCII_ZERO && raw <= ASCII_NINE) ? raw - ASCII_ZERO : raw;
            if (fifo_fill < FRAME_BYTES_DEF) begin
                slot = fifo_rd + fifo_fill[2:0];
                frame_store[slot] = c;
                fifo_fill = fifo_fill + 4'd1;
            end
            if (fifo_fill == FRAME_BYTES_DEF) begin
                r.frame_accepted = 1'b1;
                // stop popping at the first header byte that differs
                for (int k = 0; k < 4; k++) begin
                    if (r.frame_accepted && pop_frame_byte() != FRAME_HEADER[8*k +: 8])
                        r.frame_accepted = 1'b0;
                end
                if (r.frame_accepted) begin
                    for (int k = 0; k < 4; k++) begin
                        c = pop_frame_byte();
                        if (k == shown_slot) held_digit = c;
                    end
                end
            end
        end else begin
            if (ticks_to_relatch == 0) begin
                seg_step = '0;
                if (held_digit == BLANK_VALUE) begin
                    lit_pattern = BLANK_PATTERN;
                end else begin
                    lit_pattern = (held_digit <= MAX_DIGIT) ? held_digit[3:0] : INVALID_PATTERN;
                    len = 16'($countones(seg_mask(lit_pattern)));
                    ticks_to_relatch = (display_period / len) * len;
                end
            end
            if (ticks_to_relatch != 0 && lit_pattern <= INVALID_PATTERN) begin
                segs = seg_mask(lit_pattern);
                len = 16'($countones(segs));
                found = 0;
                for (int s = 0; s < 7; s++) begin
                    if (segs[s]) begin
                        if (found == seg_step) seg = s[2:0];
                        found++;
                    end
                end
                anode = ANODE_PINS[3*seg +: 3];
                cathode = CATHODE_PINS[3*seg +: 3];
                r.drive_enable = (5'd1 << anode) | (5'd1 << cathode);
                r.drive_high = 5'd1 << anode;
                seg_step = (seg_step + 1 >= len) ? 3'd0 : seg_step + 3'd1;
                ticks_to_relatch = ticks_to_relatch - 16'd1;
            end
        end
        r.shown_value = held_digit;
        awaited_drives.push_back(r);
    endtask

    task automatic note_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        if (mismatches < REPORT_CAP)
            $display("mismatch on %s at result %0d: got %0d, expected %0d",
                     what, results_seen, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : check_results
        digit_drive_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_drives.size() == 0) begin
                note_mismatch("result with nothing pending", 16'(m_shown_value), 16'd0);
            end else begin
                want = awaited_drives.pop_front();
                if (m_drive_enable !== want.drive_enable)
                    note_mismatch("drive_enable", 16'(m_drive_enable),
                                  16'(want.drive_enable));
                if (m_drive_high !== want.drive_high)
                    note_mismatch("drive_high", 16'(m_drive_high), 16'(want.drive_high));
                if (m_frame_accepted !== want.frame_accepted)
                    note_mismatch("frame_accepted", 16'(m_frame_accepted),
                                  16'(want.frame_accepted));
                if (m_shown_value !== want.shown_value)
                    note_mismatch("shown_value", 16'(m_shown_value), 16'(want.shown_value));
            end
            results_seen++;
        end
    end

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (ready_holdoff > 0) begin
                m_ready <= 1'b0;
                ready_holdoff--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                stall_left = pick_idle();
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input logic op, input logic [7:0] value);
        int gap;
        gap = sender_idles ? pick_idle() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_byte_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
        step_digit(op, value);
    endtask

    // drop the request and wait until the block has nothing left in work
    task automatic settle_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_drives.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_DIGIT_POSITION) shown_slot = value[1:0];
        else display_period = value;
    endtask

    // header plus four time bytes; bad_slot < 0 keeps the header intact
    task automatic send_frame(input logic ascii_header, input int bad_slot,
                              input logic [31:0] times, input logic mix_ticks);
        logic [7:0] b;
        for (int k = 0; k < 8; k++) begin
            if (k < 4) begin
                b = FRAME_HEADER[8*k +: 8];
                if (ascii_header) b = b + ASCII_ZERO;
                if (k == bad_slot) b = b ^ (8'd1 << $urandom_range(0, 7));
            end else begin
                b = times[8*(k-4) +: 8];
            end
            send_request(OP_BYTE, b);
            if (mix_ticks && $urandom_range(0, 4) == 0)
                send_request(OP_TICK, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_traffic(input int n);
        int first;
        first = requests_sent;
        while (requests_sent - first < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    send_frame(1'($urandom_range(0, 1)),
                               ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : -1,
                               {random_time_byte(), random_time_byte(),
                                random_time_byte(), random_time_byte()}, 1'b1);
                6, 7:
                    repeat ($urandom_range(1, 6))
                        send_request(OP_TICK, 8'($urandom_range(0, 255)));
                default:
                    send_request(OP_BYTE, 8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // reset value of the shown value is outside 0..9, so the fallback pattern lights
    task automatic test_invalid_value();
        settle_block();
        write_reg(REG_DISPLAY_PERIOD, 16'd3);
        repeat (3) send_request(OP_TICK, 8'hA5);
    endtask

    // ascii header and digits plus one non-digit byte, digit position still at its reset value
    task automatic test_ascii_frame();
        send_frame(1'b1, -1, {ASCII_ZERO, 8'hFF, ASCII_NINE, ASCII_ZERO + 8'd8}, 1'b0);
    endtask

    // eight needs seven ticks, the period only gives three
    task automatic test_short_period();
        send_request(OP_TICK, 8'h5A);
    endtask

    task automatic test_blank_value();
        settle_block();
        write_reg(REG_DIGIT_POSITION, 16'd2);
        send_frame(1'b0, -1, {8'd0, BLANK_VALUE, 8'd58, 8'd47}, 1'b0);
        repeat (2) send_request(OP_TICK, 8'h00);
    endtask

    task automatic test_random_traffic(input logic [1:0] slot, input logic [15:0] period,
                                       input int n);
        settle_block();
        write_reg(REG_DIGIT_POSITION, {14'd0, slot});
        write_reg(REG_DISPLAY_PERIOD, period);
        run_traffic(n);
    endtask

    // sink holds off while requests keep coming, no idling on either side
    task automatic test_backpressure();
        settle_block();
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        @(posedge aclk);
        ready_holdoff = HOLDOFF;
        run_traffic(60);
        settle_block();
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // run out the current period first so the longest one really gets latched
    task automatic test_long_period();
        while (ticks_to_relatch != 0) send_request(OP_TICK, 8'($urandom_range(0, 255)));
        settle_block();
        write_reg(REG_DIGIT_POSITION, 16'd3);
        write_reg(REG_DISPLAY_PERIOD, 16'hFFFF);
        run_traffic(80);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = OP_BYTE;
        s_byte_value = 8'd0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_DIGIT_POSITION;
        cfg_wdata = 16'd0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        test_invalid_value();
        test_ascii_frame();
        test_short_period();
        test_blank_value();
        test_random_traffic(2'd0, 16'd1, 90);
        test_random_traffic(2'd1, 16'd2, 90);
        test_random_traffic(2'd2, 16'd9, 100);
        test_random_traffic(2'd3, 16'($urandom_range(3, 30)), 100);
        test_backpressure();
        test_random_traffic(2'($urandom_range(0, 3)), 16'($urandom_range(1, 40)), 100);
        test_long_period();

        settle_block();
        if (mismatches == 0) begin
            $display("** charlieplex_digit_frame_display: PASSED **");
        end else begin
            $display("** charlieplex_digit_frame_display: FAILED **");
        end
        $finish;
    end

endmodule
